>>> rtl/core/mcct_pkg.sv
// types, codes and constants shared by the compare timer core
`timescale 1ns / 1ps
`default_nettype none

package mcct_pkg;

    localparam int NUM_CHANNELS   = 4;
    localparam int COUNT_WIDTH    = 24;
    localparam int PRESCALE_WIDTH = 12;
    localparam int OP_WIDTH       = 2;
    localparam int CHAN_WIDTH     = 2;
    localparam int DELAY_WIDTH    = 24;

    localparam logic [OP_WIDTH-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_START = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_STOP  = 2'd2;

    typedef struct packed {
        logic [OP_WIDTH-1:0]    opcode;
        logic [CHAN_WIDTH-1:0]  channel;
        logic                   repeat_req;
        logic [DELAY_WIDTH-1:0] delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0] fired_mask;
        logic [NUM_CHANNELS-1:0] active_mask;
        logic [COUNT_WIDTH-1:0]  count_now;
    } out_item_t;

    typedef struct packed {
        logic advance;
        logic start;
        logic stop;
    } chan_ctrl_t;

    typedef struct packed {
        logic armed;
        logic fire;
        logic armed_next;
    } chan_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mcct_chan.sv
// one compare channel: compare value, reload period and armed flag
`timescale 1ns / 1ps
`default_nettype none

module mcct_chan (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire mcct_pkg::chan_ctrl_t           ctrl,
    input  wire logic [mcct_pkg::COUNT_WIDTH-1:0] count_cur,
    input  wire logic [mcct_pkg::COUNT_WIDTH-1:0] count_adv,
    input  wire logic [mcct_pkg::COUNT_WIDTH-1:0] delay,
    input  wire logic                           repeat_req,
    output mcct_pkg::chan_stat_t                stat
);
    import mcct_pkg::*;

    logic                   armed_reg;
    logic                   armed_next;
    logic [COUNT_WIDTH-1:0] compare_reg;
    logic [COUNT_WIDTH-1:0] compare_next;
    logic [COUNT_WIDTH-1:0] period_reg;
    logic [COUNT_WIDTH-1:0] period_next;
    logic                   fire;

    assign fire = armed_reg && ctrl.advance && (compare_reg == count_adv);

    always_comb begin
        armed_next   = armed_reg;
        compare_next = compare_reg;
        period_next  = period_reg;
        if (ctrl.start) begin
            period_next  = repeat_req ? delay : '0;
            compare_next = count_cur + delay;
            armed_next   = 1'b1;
        end else if (ctrl.stop) begin
            period_next = '0;
            armed_next  = 1'b0;
        end else if (fire) begin
            if (period_reg == '0) begin
                armed_next = 1'b0;
            end else begin
                compare_next = compare_reg + period_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg   <= 1'b0;
            compare_reg <= '0;
            period_reg  <= '0;
        end else begin
            armed_reg   <= armed_next;
            compare_reg <= compare_next;
            period_reg  <= period_next;
        end
    end

    assign stat.armed      = armed_reg;
    assign stat.fire       = fire;
    assign stat.armed_next = armed_next;

endmodule

`default_nettype wire

>>> rtl/core/multi_channel_compare_timer_core.sv
// top level of the multi-channel compare timer with prescaler and auto-reload
//
// Takes one item per clock cycle unless the output stalls and returns one result per
// item. An accepted item lands in an input register; once the result register is free
// or being taken, it is applied to the counter, prescaler and all channels at once and
// loads the result register. The single pass of counter increment, the parallel compare
// of every channel and the compare reload between those two registers sets the one item
// per cycle figure. s_ready follows m_ready when both registers are full. cfg_wr_en writes
// the prescale divider; the user must use it only while idle, the core does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_compare_timer_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire mcct_pkg::in_item_t                  s_item,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output mcct_pkg::out_item_t                      m_item,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mcct_pkg::PRESCALE_WIDTH-1:0] cfg_wr_data
);
    import mcct_pkg::*;

    in_item_t                  in_reg;
    logic                      in_vld_reg;
    out_item_t                 out_reg;
    out_item_t                 out_next;
    logic                      out_vld_reg;
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic [COUNT_WIDTH-1:0]    count_next;
    logic [COUNT_WIDTH-1:0]    count_inc;
    logic [PRESCALE_WIDTH-1:0] psc_reg;
    logic [PRESCALE_WIDTH-1:0] psc_next;
    logic [PRESCALE_WIDTH-1:0] div_reg;
    logic [COUNT_WIDTH-1:0]    delay;
    logic                      move;
    logic                      is_tick;
    logic                      do_tick;
    logic                      do_adv;
    logic [NUM_CHANNELS-1:0]   armed_mask;
    logic [NUM_CHANNELS-1:0]   fire_mask;
    logic [NUM_CHANNELS-1:0]   armed_next_mask;
    chan_ctrl_t                ctrl [NUM_CHANNELS];
    chan_stat_t                stat [NUM_CHANNELS];

    assign move    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || move;
    assign m_valid = out_vld_reg;
    assign m_item  = out_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    // prescaler and counter
    assign delay     = COUNT_WIDTH'(in_reg.delay_ticks);
    assign is_tick   = move && (in_reg.opcode == OP_TICK);
    assign do_tick   = is_tick && (armed_mask != '0);
    assign do_adv    = do_tick && (psc_reg >= div_reg);
    assign count_inc = count_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        psc_next   = psc_reg;
        if (do_adv) begin
            count_next = count_inc;
            psc_next   = '0;
        end else if (do_tick) begin
            psc_next = psc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            psc_reg   <= '0;
            div_reg   <= '0;
        end else begin
            count_reg <= count_next;
            psc_reg   <= psc_next;
            if (cfg_wr_en) begin
                div_reg <= cfg_wr_data;
            end
        end
    end

    // channels
    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
        assign ctrl[i].advance = do_adv;
        assign ctrl[i].start   = move && (in_reg.opcode == OP_START)
                                 && (in_reg.channel == CHAN_WIDTH'(i));
        assign ctrl[i].stop    = move && (in_reg.opcode == OP_STOP)
                                 && (in_reg.channel == CHAN_WIDTH'(i));

        mcct_chan u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl[i]),
            .count_cur  (count_reg),
            .count_adv  (count_inc),
            .delay      (delay),
            .repeat_req (in_reg.repeat_req),
            .stat       (stat[i])
        );

        assign armed_mask[i]      = stat[i].armed;
        assign fire_mask[i]       = stat[i].fire;
        assign armed_next_mask[i] = stat[i].armed_next;
    end

    // result register
    always_comb begin
        out_next.fired_mask  = fire_mask;
        out_next.active_mask = armed_next_mask;
        out_next.count_now   = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (move) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_reg <= out_next;
        end
    end

    // checks
    a_fire_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        move && (in_reg.opcode != OP_TICK) |=> m_item.fired_mask == '0)
        else $error("fired mask set on an item that is not a tick");

    a_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !is_tick |=> $stable(count_reg))
        else $error("counter moved without a tick");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        is_tick |=> (count_reg == $past(count_reg))
                    || (count_reg == COUNT_WIDTH'($past(count_reg) + 1'b1)))
        else $error("counter advanced by more than one");

    a_idle_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_mask == '0 |=> $stable(count_reg) && $stable(psc_reg))
        else $error("counter or prescaler ran with no channel armed");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the multi-channel compare timer core
module tb_top;
    import mcct_pkg::*;

    localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 64;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    in_item_t                  s_item;
    logic                      m_valid;
    logic                      m_ready;
    out_item_t                 m_item;
    logic                      cfg_wr_en;
    logic [PRESCALE_WIDTH-1:0] cfg_wr_data;

    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic hold_kick  = 1'b0;

    logic [COUNT_WIDTH-1:0]    tmr_count;
    logic [PRESCALE_WIDTH-1:0] tmr_phase;
    logic [PRESCALE_WIDTH-1:0] tmr_divide;
    logic [COUNT_WIDTH-1:0]    tmr_cmp [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]    tmr_per [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]   tmr_armed;

    out_item_t   pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    multi_channel_compare_timer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // timer behavior: applies one item to the shadow state, returns the result it causes
    function automatic out_item_t timer_step(input in_item_t it);
        out_item_t res;
        logic [NUM_CHANNELS-1:0] fired;
        int ch;
        fired = '0;
        ch = int'(it.channel);
        case (it.opcode)
            OP_TICK: begin
                if (tmr_armed != '0) begin
                    if (tmr_phase >= tmr_divide) begin
                        tmr_phase = '0;
                        tmr_count = tmr_count + 1'b1;
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            if (tmr_armed[c] && tmr_cmp[c] == tmr_count) begin
                                fired[c] = 1'b1;
                                if (tmr_per[c] == '0) begin
                                    tmr_armed[c] = 1'b0;
                                end else begin
                                    tmr_cmp[c] = tmr_cmp[c] + tmr_per[c];
                                end
                            end
                        end
                    end else begin
                        tmr_phase = tmr_phase + 1'b1;
                    end
                end
            end
            OP_START: begin
                if (ch < NUM_CHANNELS) begin
                    tmr_per[ch]   = it.repeat_req ? it.delay_ticks : '0;
                    tmr_cmp[ch]   = tmr_count + it.delay_ticks;
                    tmr_armed[ch] = 1'b1;
                end
            end
            OP_STOP: begin
                if (ch < NUM_CHANNELS) begin
                    tmr_per[ch]   = '0;
                    tmr_armed[ch] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.fired_mask  = fired;
        res.active_mask = tmr_armed;
        res.count_now   = tmr_count;
        return res;
    endfunction

    function automatic dir_row_t row(input logic [OP_WIDTH-1:0] op, input int chan,
                                     input logic rep, input logic [DELAY_WIDTH-1:0] dly,
                                     input logic typed, input logic [3:0] fm,
                                     input logic [3:0] am, input logic [COUNT_WIDTH-1:0] cnt);
        dir_row_t r;
        r.item.opcode      = op;
        r.item.channel     = chan[CHAN_WIDTH-1:0];
        r.item.repeat_req  = rep;
        r.item.delay_ticks = dly;
        r.typed            = typed;
        r.want.fired_mask  = fm;
        r.want.active_mask = am;
        r.want.count_now   = cnt;
        return r;
    endfunction

    // mostly ticks and short-delay starts so channels keep firing
    function automatic in_item_t rand_item();
        in_item_t it;
        logic [31:0] raw;
        logic [31:0] sel;
        int unsigned pick;
        raw  = $urandom;
        sel  = $urandom;
        pick = $urandom_range(0, 99);
        it.channel     = sel[1:0];
        it.repeat_req  = sel[2];
        it.delay_ticks = raw[23:0];
        if (pick < 55) begin
            it.opcode = OP_TICK;
        end else if (pick < 80) begin
            it.opcode = OP_START;
            if (sel[7:4] < 4'd10) begin
                it.delay_ticks = {19'd0, sel[12:8]} + 24'd1;
            end else if (sel[7:4] < 4'd12) begin
                it.delay_ticks = '0;
            end
        end else if (pick < 93) begin
            it.opcode = OP_STOP;
        end else begin
            it.opcode = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic push_item(input in_item_t it, input out_item_t want);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        pending_results.push_back(want);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_random(input int unsigned count);
        in_item_t it;
        out_item_t want;
        repeat (count) begin
            it   = rand_item();
            want = timer_step(it);
            push_item(it, want);
        end
    endtask

    task automatic write_divide(input int unsigned value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_data <= value[PRESCALE_WIDTH-1:0];
        cfg_wr_en   <= 1'b1;
        tmr_divide  = value[PRESCALE_WIDTH-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : main_seq
        dir_row_t  dir_rows [$];
        out_item_t want;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        tmr_count   = '0;
        tmr_phase   = '0;
        tmr_divide  = '0;
        tmr_armed   = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            tmr_cmp[c] = '0;
            tmr_per[c] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b1, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_UNUSED, 0, 1'b0, 24'd0,       1'b1, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_STOP,   2, 1'b0, 24'd0,       1'b1, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_START,  0, 1'b0, 24'd3,       1'b1, 4'h0, 4'h1, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_START,  1, 1'b1, 24'd2,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   3, 1'b1, 24'hFFFFFF,  1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_START,  2, 1'b1, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_START,  3, 1'b1, 24'hFFFFFF,  1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_START,  1, 1'b0, 24'd1,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_STOP,   2, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_STOP,   3, 1'b1, 24'hFFFFFF,  1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_START,  0, 1'b1, 24'd1,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_TICK,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_UNUSED, 3, 1'b1, 24'hFFFFFF,  1'b0, 4'h0, 4'h0, 24'd0));
        dir_rows.push_back(row(OP_STOP,   0, 1'b0, 24'd0,       1'b0, 4'h0, 4'h0, 24'd0));

        foreach (dir_rows[i]) begin
            want = timer_step(dir_rows[i].item);
            if (dir_rows[i].typed) begin
                want = dir_rows[i].want;
            end
            push_item(dir_rows[i].item, want);
        end

        run_random(250);
        write_divide(12'hFFF);
        run_random(80);
        // phase left over from the slow setting exceeds the new divider
        write_divide(1);
        hold_kick <= 1'b1;
        run_random(120);
        write_divide($urandom_range(2, 6));
        run_random(100);
        write_divide(0);
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b0;
        run_random(150);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned n;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_kick) begin
                // long hold so the core backs up and drops s_ready
                hold_kick <= 1'b0;
                m_ready   <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = rx_idle_on ? $urandom_range(1, 20) : 1;
                repeat (n) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected item: got %h", $time, m_item);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_item.fired_mask !== want.fired_mask) begin
                    $display("%0t fired_mask mismatch: expected %h, got %h",
                             $time, want.fired_mask, m_item.fired_mask);
                    mismatch_count++;
                end
                if (m_item.active_mask !== want.active_mask) begin
                    $display("%0t active_mask mismatch: expected %h, got %h",
                             $time, want.active_mask, m_item.active_mask);
                    mismatch_count++;
                end
                if (m_item.count_now !== want.count_now) begin
                    $display("%0t count_now mismatch: expected %h, got %h",
                             $time, want.count_now, m_item.count_now);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t timeout with %0d items outstanding", $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
